/* design/keyboard_scan_code_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Keyboard scan code decoder assertion macros
// Shared property shorthands, clocked on i_clk and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCAN_CODE_DECODER_UNIT_ASSERT_SVH
`define KEYBOARD_SCAN_CODE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define KSCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kscd: same-cycle check failed");

// next-cycle implication
`define KSCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kscd: next-cycle check failed");

`endif

/* design/kscd_pkg.sv */
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared constants and types of the keyboard scan code decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kscd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W     = 12;
    localparam int ODATA_W     = 16;

    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MK    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_ALT_MK     = 8'h38;
    localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
    localparam logic [7:0] SC_CAPS       = 8'h3A;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic       caps;
        logic       alt;
        logic       ctrl;
        logic       shift;
        logic [7:0] code;
    } t_entry;

    typedef struct packed {
        logic   vld;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic vld;
        logic hit;
    } t_rd;

endpackage

/* design/kscd_ram.sv */
// ----------------------------------------------------------------------------
// kscd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kscd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/kscd_mod.sv */
// ----------------------------------------------------------------------------
// kscd_mod
// Modifier and prefix tracker; builds the queue entry for plain key bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kscd_mod import kscd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_vld,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    logic r_prefix, r_lshift, r_rshift, r_lctrl, r_rctrl, r_lalt, r_ralt, r_caps;
    logic n_prefix, n_lshift, n_rshift, n_lctrl, n_rctrl, n_lalt, n_ralt, n_caps;
    logic key_byte;

    always_comb begin
        n_prefix = r_prefix;
        n_lshift = r_lshift;
        n_rshift = r_rshift;
        n_lctrl  = r_lctrl;
        n_rctrl  = r_rctrl;
        n_lalt   = r_lalt;
        n_ralt   = r_ralt;
        n_caps   = r_caps;
        key_byte = 1'b0;
        if (i_byte_vld) begin
            if (i_byte == SC_PREFIX) begin
                n_prefix = 1'b1;
            end else if (r_prefix) begin
                n_prefix = 1'b0;
                case (i_byte)
                    SC_CTRL_MK:  n_rctrl = 1'b1;
                    SC_CTRL_BRK: n_rctrl = 1'b0;
                    SC_ALT_MK:   n_ralt  = 1'b1;
                    SC_ALT_BRK:  n_ralt  = 1'b0;
                    default:     n_prefix = 1'b0;
                endcase
            end else begin
                case (i_byte)
                    SC_LSHIFT_MK:  n_lshift = 1'b1;
                    SC_LSHIFT_BRK: n_lshift = 1'b0;
                    SC_RSHIFT_MK:  n_rshift = 1'b1;
                    SC_RSHIFT_BRK: n_rshift = 1'b0;
                    SC_CTRL_MK:    n_lctrl  = 1'b1;
                    SC_CTRL_BRK:   n_lctrl  = 1'b0;
                    SC_ALT_MK:     n_lalt   = 1'b1;
                    SC_ALT_BRK:    n_lalt   = 1'b0;
                    SC_CAPS:       n_caps   = ~r_caps;
                    default:       key_byte = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_lshift <= 1'b0;
            r_rshift <= 1'b0;
            r_lctrl  <= 1'b0;
            r_rctrl  <= 1'b0;
            r_lalt   <= 1'b0;
            r_ralt   <= 1'b0;
            r_caps   <= 1'b0;
        end else begin
            r_prefix <= n_prefix;
            r_lshift <= n_lshift;
            r_rshift <= n_rshift;
            r_lctrl  <= n_lctrl;
            r_rctrl  <= n_rctrl;
            r_lalt   <= n_lalt;
            r_ralt   <= n_ralt;
            r_caps   <= n_caps;
        end
    end

    assign o_push.vld         = key_byte;
    assign o_push.entry.code  = i_byte;
    assign o_push.entry.shift = r_lshift | r_rshift;
    assign o_push.entry.ctrl  = r_lctrl | r_rctrl;
    assign o_push.entry.alt   = r_lalt | r_ralt;
    assign o_push.entry.caps  = r_caps;

endmodule

/* design/kscd_out.sv */
// ----------------------------------------------------------------------------
// kscd_out
// Read response path: RAM data stage and registered master-side output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kscd_out import kscd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rd                i_rd,
    input  t_entry             i_ram_q,
    output logic               o_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ODATA_W-1:0] m_tdata,
    output logic               m_tuser
);

    logic               r_p1_vld, n_p1_vld;
    logic               r_p1_hit;
    logic               r_m_vld, n_m_vld;
    logic               r_m_hit;
    logic [ODATA_W-1:0] r_m_data;
    logic               p1_adv;

    assign p1_adv  = r_p1_vld && (!r_m_vld || m_tready);
    assign o_ready = !r_p1_vld || p1_adv;

    always_comb begin
        n_p1_vld = r_p1_vld;
        if (i_rd.vld) begin
            n_p1_vld = 1'b1;
        end else if (p1_adv) begin
            n_p1_vld = 1'b0;
        end
        n_m_vld = r_m_vld;
        if (p1_adv) begin
            n_m_vld = 1'b1;
        end else if (m_tready) begin
            n_m_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_m_vld  <= 1'b0;
        end else begin
            r_p1_vld <= n_p1_vld;
            r_m_vld  <= n_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.vld) begin
            r_p1_hit <= i_rd.hit;
        end
        if (p1_adv) begin
            r_m_hit  <= r_p1_hit;
            r_m_data <= r_p1_hit ? {{(ODATA_W-ENTRY_W){1'b0}}, i_ram_q} : '0;
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tuser  = r_m_hit;
    assign m_tdata  = r_m_data;

endmodule

/* design/keyboard_scan_code_decoder_unit.sv */
// ----------------------------------------------------------------------------
// keyboard_scan_code_decoder_unit
// Set 1 scan code decoder with modifier tracking and a key queue in RAM.
//
//   Channel  Dir  tdata (low bit up)                          tuser
//   s_*      in   sc_byte[7:0]                                mode
//   m_*      out  key_code[7:0], shift, ctrl, alt, caps, 0*4   key_valid
//
// One request per cycle while s_tready is high; read answers leave on m_*.
// Queue pointers and modifier flags update at acceptance; the queue RAM
// (one write port, one registered read port) is read the same cycle.
// Synchronous active-low reset clears flags and pointers; queue data is not
// cleared. s_tready drops only while a read answer waits behind a stalled m_*.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyboard_scan_code_decoder_unit import kscd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // sc_byte[7:0]
    input  logic               s_tuser,   // mode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ODATA_W-1:0] m_tdata,   // key_code[7:0], shift, ctrl, alt, caps, pad
    output logic               m_tuser    // key_valid
);

    `include "keyboard_scan_code_decoder_unit_assert.svh"

    logic              acc;
    logic              rd_acc;
    logic              q_empty, q_full;
    logic [QPTR_W-1:0] r_rd_ptr, r_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] rd_inc, wr_inc;
    logic              ram_we, ram_re;
    t_push             push;
    t_rd               rd;
    t_entry            ram_q;

    assign acc    = s_tvalid && s_tready;
    assign rd_acc = acc && (s_tuser == MODE_READ);

    kscd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (acc && (s_tuser == MODE_BYTE)),
        .i_byte     (s_tdata),
        .o_push     (push)
    );

    assign rd_inc  = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign wr_inc  = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign q_empty = (r_rd_ptr == r_wr_ptr);
    assign q_full  = (wr_inc == r_rd_ptr);

    assign ram_we = push.vld && !q_full;
    assign ram_re = rd_acc && !q_empty;

    assign n_wr_ptr = ram_we ? wr_inc : r_wr_ptr;
    assign n_rd_ptr = ram_re ? rd_inc : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    kscd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (push.entry),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    assign rd.vld = rd_acc;
    assign rd.hit = !q_empty;

    kscd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (rd),
        .i_ram_q  (ram_q),
        .o_ready  (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `KSCD_ASSERT_IMP(a_no_write_when_full, ram_we, wr_inc != r_rd_ptr)
    `KSCD_ASSERT_IMP(a_push_only_on_byte, push.vld, acc && (s_tuser == MODE_BYTE))
    `KSCD_ASSERT_NXT(a_empty_read_holds_ptr, rd_acc && q_empty, r_rd_ptr == $past(r_rd_ptr))
    `KSCD_ASSERT_IMP(a_miss_has_zero_data, m_tvalid && !m_tuser, m_tdata == '0)

endmodule
